@@ rtl/rpn_pkg.sv @@
package rpn_pkg;

	localparam int unsigned DATA_W      = 32;
	localparam int unsigned CMD_W       = 3;
	localparam int unsigned DIGIT_W     = 4;
	localparam int unsigned DEPTH_OUT_W = 5;
	localparam int unsigned STATUS_W    = 2;
	localparam int unsigned STACK_DEPTH_DEF = 16;

	localparam logic [CMD_W-1:0] CMD_ADD   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_SUB   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_MUL   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DIV   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_PUSH  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd5;
	localparam logic [CMD_W-1:0] CMD_DIGIT = 3'd6;
	localparam logic [CMD_W-1:0] CMD_NOP   = 3'd7;

	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_UNDER = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_DIVZ  = 2'd3;

endpackage

@@ rtl/rpn_if.sv @@
interface rpn_req_if import rpn_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   cmd;
	logic [DIGIT_W-1:0] digit;

	modport source (output valid, cmd, digit, input ready);
	modport sink   (input valid, cmd, digit, output ready);
endinterface

interface rpn_rsp_if import rpn_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic signed [DATA_W-1:0]      top_value;
	logic        [DEPTH_OUT_W-1:0] stack_depth;
	logic signed [DATA_W-1:0]      entry_value;
	logic        [STATUS_W-1:0]    status;

	modport source (output valid, top_value, stack_depth, entry_value, status, input ready);
	modport sink   (input valid, top_value, stack_depth, entry_value, status, output ready);
endinterface

@@ rtl/rpn_stack_calculator.sv @@
// Reverse-Polish integer calculator.
// req carries one command beat (cmd, digit); rsp returns one beat per command:
// top of stack (zero when empty), depth, entry register and a status code.
// Arithmetic pops two entries and pushes (top op second); push moves the entry
// register onto the stack and clears it; a digit beat does entry*10+digit.
// Underflow, push onto a full stack and divide by zero change nothing.
// The stack lives in a synchronous RAM with one read and one write port; the top
// entry is mirrored in a register so an operation needs one RAM read (second
// entry) and one write.
// From req accept to rsp valid a command passes the EXEC and DONE states and
// the output register; a divide that runs passes EXEC, 32 steps of a radix-2
// restoring divider in DIV (one bit per cycle), DFIN and DONE. One command is
// in flight at a time; a new command is taken once the sequencer is back in
// IDLE. req is ready again once the result is loaded into the output register,
// so a new command is taken while an earlier result still waits on rsp.
// When rsp stalls, the result holds in the output register; a following result
// waits in the sequencer and req stays low until it can be loaded.
// Reset empties the stack and clears the entry register; no RAM sweep is needed.
module rpn_stack_calculator import rpn_pkg::*; #(
	parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
	input logic      clk,
	input logic      arst_n,
	rpn_req_if.sink  req,
	rpn_rsp_if.source rsp
);

	localparam int unsigned AW = $clog2(STACK_DEPTH);
	localparam int unsigned DW = $clog2(STACK_DEPTH + 1);
	localparam int unsigned CW = $clog2(DATA_W);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EXEC = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_DFIN = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]          state_q;
	logic [CMD_W-1:0]    cmd_q;
	logic [DIGIT_W-1:0]  digit_q;
	logic [DW-1:0]       depth_q;
	logic [DATA_W-1:0]   top_q;
	logic [DATA_W-1:0]   entry_q;
	logic [STATUS_W-1:0] status_q;

	// stack RAM
	logic [DATA_W-1:0] mem [STACK_DEPTH];
	logic [DATA_W-1:0] rd_q;
	logic [AW-1:0]     rd_addr;
	logic              mem_we;
	logic [AW-1:0]     mem_wa;
	logic [DATA_W-1:0] mem_wd;

	// divider
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] dvd_q;
	logic [DATA_W-1:0] dvs_q;
	logic              qneg_q;
	logic [CW-1:0]     cnt_q;
	logic [DATA_W:0]   div_shift;
	logic [DATA_W:0]   div_diff;

	// output register
	logic              out_valid_q;
	logic [DATA_W-1:0] out_top_q;
	logic [DEPTH_OUT_W-1:0] out_depth_q;
	logic [DATA_W-1:0] out_entry_q;
	logic [STATUS_W-1:0] out_status_q;

	logic [DATA_W-1:0] op_a;
	logic [DATA_W-1:0] op_b;
	logic [DATA_W-1:0] arith_r;
	logic [DATA_W-1:0] ua;
	logic [DATA_W-1:0] ub;
	logic [DATA_W-1:0] quot;
	logic [DW-1:0]     depth_m1;
	logic [DW-1:0]     depth_m2;
	logic [DW+DEPTH_OUT_W-1:0] depth_ext;
	logic              under;
	logic              full;
	logic              out_free;

	assign depth_m1 = depth_q - DW'(1);
	assign depth_m2 = depth_q - DW'(2);
	assign under    = depth_q < DW'(2);
	assign full     = depth_q >= DW'(STACK_DEPTH);
	assign rd_addr  = depth_m2[AW-1:0];
	assign op_a     = top_q;
	assign op_b     = rd_q;
	assign ua       = op_a[DATA_W-1] ? DATA_W'(0) - op_a : op_a;
	assign ub       = op_b[DATA_W-1] ? DATA_W'(0) - op_b : op_b;
	assign quot     = qneg_q ? DATA_W'(0) - dvd_q : dvd_q;
	assign depth_ext = {{DEPTH_OUT_W{1'b0}}, depth_q};
	assign out_free  = !out_valid_q || rsp.ready;

	assign div_shift = {rem_q, dvd_q[DATA_W-1]};
	assign div_diff  = div_shift - {1'b0, dvs_q};

	always_comb begin
		case (cmd_q)
			CMD_ADD: arith_r = op_a + op_b;
			CMD_SUB: arith_r = op_a - op_b;
			CMD_MUL: arith_r = DATA_W'(op_a * op_b);
			default: arith_r = op_a + op_b;
		endcase
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = depth_m2[AW-1:0];
		mem_wd = arith_r;
		case (state_q)
			ST_EXEC: begin
				if (cmd_q == CMD_ADD || cmd_q == CMD_SUB || cmd_q == CMD_MUL) begin
					mem_we = !under;
				end else if (cmd_q == CMD_PUSH) begin
					mem_we = !full;
					mem_wa = depth_q[AW-1:0];
					mem_wd = entry_q;
				end
			end
			ST_DFIN: begin
				mem_we = 1'b1;
				mem_wd = quot;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[rd_addr];
	end

	assign req.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			depth_q     <= '0;
			entry_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_DONE;
					case (cmd_q)
						CMD_ADD, CMD_SUB, CMD_MUL: begin
							if (!under) begin
								depth_q <= depth_m1;
							end
						end
						CMD_DIV: begin
							if (!under && op_b != '0) begin
								state_q <= ST_DIV;
							end
						end
						CMD_PUSH: begin
							if (!full) begin
								depth_q <= depth_q + DW'(1);
								entry_q <= '0;
							end
						end
						CMD_CLEAR: depth_q <= '0;
						CMD_DIGIT: entry_q <= (entry_q << 3) + (entry_q << 1)
							+ DATA_W'(digit_q);
						default: begin
							state_q <= ST_DONE;
						end
					endcase
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_DFIN;
					end
				end
				ST_DFIN: begin
					depth_q <= depth_m1;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload and datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cmd_q   <= req.cmd;
				digit_q <= req.digit;
			end
			ST_EXEC: begin
				status_q <= STAT_OK;
				case (cmd_q)
					CMD_ADD, CMD_SUB, CMD_MUL: begin
						if (under) begin
							status_q <= STAT_UNDER;
						end else begin
							top_q <= arith_r;
						end
					end
					CMD_DIV: begin
						if (under) begin
							status_q <= STAT_UNDER;
						end else if (op_b == '0) begin
							status_q <= STAT_DIVZ;
						end
						rem_q  <= '0;
						dvd_q  <= ua;
						dvs_q  <= ub;
						qneg_q <= op_a[DATA_W-1] ^ op_b[DATA_W-1];
						cnt_q  <= CW'(DATA_W - 1);
					end
					CMD_PUSH: begin
						if (full) begin
							status_q <= STAT_FULL;
						end else begin
							top_q <= entry_q;
						end
					end
					default: begin
						status_q <= STAT_OK;
					end
				endcase
			end
			ST_DIV: begin
				// one quotient bit per cycle, shifted in where the dividend leaves
				if (!div_diff[DATA_W]) begin
					rem_q <= div_diff[DATA_W-1:0];
				end else begin
					rem_q <= div_shift[DATA_W-1:0];
				end
				dvd_q <= {dvd_q[DATA_W-2:0], !div_diff[DATA_W]};
				cnt_q <= cnt_q - CW'(1);
			end
			ST_DFIN: begin
				top_q <= quot;
			end
			ST_DONE: begin
				if (out_free) begin
					out_top_q    <= (depth_q != '0) ? top_q : '0;
					out_depth_q  <= depth_ext[DEPTH_OUT_W-1:0];
					out_entry_q  <= entry_q;
					out_status_q <= status_q;
				end
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.top_value   = out_top_q;
	assign rsp.stack_depth = out_depth_q;
	assign rsp.entry_value = out_entry_q;
	assign rsp.status      = out_status_q;

`ifndef NO_ASSERTIONS
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DW'(STACK_DEPTH))
		else $error("stack depth beyond capacity");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> state_q == ST_EXEC)
		else $error("accepted command not executed");

	a_under_depth: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) && rsp.status == STAT_UNDER |-> depth_q < DW'(2))
		else $error("underflow reported with two or more entries");

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DFIN |-> $past(state_q) == ST_DIV && $past(cnt_q) == '0)
		else $error("divider finished early");
`endif

endmodule
